FILE: rtl/dlc_pkg.sv
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared types, widths and codes for the distance limit constraint pipeline.
// ----------------------------------------------------------------------------
package dlc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int EXTRA_BITS = 16;
	localparam int CRD_W      = 32;
	localparam int W_W        = 17;
	localparam int LIM_W      = 31;
	localparam int MAG_W      = CRD_W + 1;
	localparam int SUM_W      = 2 * MAG_W;
	localparam int RAD_W      = SUM_W + 2 * EXTRA_BITS;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 2;
	localparam int NL_W       = MAG_W + LIM_W;
	localparam int NUM_W      = NL_W + EXTRA_BITS;
	localparam int Q_W        = LIM_W;
	localparam int DIFF_W     = CRD_W + 3;
	localparam int PROD_W     = DIFF_W + W_W;
	localparam int STEP_W     = PROD_W - 16;
	localparam int RES_W      = STEP_W + 1;

	localparam logic [W_W-1:0] ONE_WEIGHT = W_W'(65536);
	localparam logic [63:0] TINY_SQ =
		((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;

	typedef enum logic {
		CFG_LIMIT = 1'b0,
		CFG_MODE  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] driver_x;
		logic signed [CRD_W-1:0] driver_y;
		logic signed [CRD_W-1:0] driver_z;
		logic signed [CRD_W-1:0] driven_x;
		logic signed [CRD_W-1:0] driven_y;
		logic signed [CRD_W-1:0] driven_z;
		logic [W_W-1:0]          influence;
	} in_item_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] result_x;
		logic signed [CRD_W-1:0] result_y;
		logic signed [CRD_W-1:0] result_z;
		logic                    moved;
	} out_item_t;

	// payload carried alongside the root and quotient stages
	typedef struct packed {
		logic [2:0][CRD_W-1:0] drv;
		logic [2:0][CRD_W-1:0] dvn;
		logic [2:0]            neg;
		logic [2:0][NUM_W-1:0] num;
		logic [W_W-1:0]        w;
		logic                  pass;
		logic                  tiny;
	} side_t;

endpackage

FILE: rtl/distance_limit_constraint_3d_core.sv
// ----------------------------------------------------------------------------
// distance_limit_constraint_3d_core
// Distance limit constraint on 3D fixed-point points, fully pipelined.
// ----------------------------------------------------------------------------
// pipeline: 3 front stages, 49 square root stages, 31 divider stages and
//   3 back stages between input accept and result valid
// throughput: one item per cycle; the whole pipeline holds while a result
//   waits under stall
// reset: valid bits and both configuration registers clear to zero
module distance_limit_constraint_3d_core
	import dlc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LIM_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_item
);

	logic [LIM_W-1:0] limit_q;
	logic             mode_q;
	logic             adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LIMIT: limit_q <= cfg_data;
				CFG_MODE:  mode_q  <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: differences and magnitudes
	logic                  vld_s1;
	logic [2:0][CRD_W-1:0] drv_s1, dvn_s1;
	logic [2:0]            neg_s1;
	logic [2:0][MAG_W-1:0] mag_s1;
	logic [W_W-1:0]        w_s1;
	logic [2:0][CRD_W-1:0] drv_c, dvn_c;
	logic [2:0][MAG_W-1:0] d_c;

	always_comb begin
		drv_c = {in_item.driver_x, in_item.driver_y, in_item.driver_z};
		dvn_c = {in_item.driven_x, in_item.driven_y, in_item.driven_z};
		for (int k = 0; k < 3; k++) begin
			d_c[k] = {dvn_c[k][CRD_W-1], dvn_c[k]} - {drv_c[k][CRD_W-1], drv_c[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// packed order puts x in the top lane, so swap to index by axis
			for (int k = 0; k < 3; k++) begin
				drv_s1[k] <= drv_c[2-k];
				dvn_s1[k] <= dvn_c[2-k];
				neg_s1[k] <= d_c[2-k][MAG_W-1];
				mag_s1[k] <= d_c[2-k][MAG_W-1] ? MAG_W'(-d_c[2-k]) : d_c[2-k];
			end
			w_s1 <= (in_item.influence > ONE_WEIGHT) ? ONE_WEIGHT : in_item.influence;
		end
	end

	// stage 2: squares and limit products
	logic                  vld_s2;
	logic [2:0][CRD_W-1:0] drv_s2, dvn_s2;
	logic [2:0]            neg_s2;
	logic [2:0][SUM_W-1:0] sq_s2;
	logic [2:0][NL_W-1:0]  nl_s2;
	logic [2*LIM_W-1:0]    lsq_s2;
	logic [W_W-1:0]        w_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= mag_s1[k] * mag_s1[k];
				nl_s2[k] <= mag_s1[k] * limit_q;
			end
			lsq_s2 <= limit_q * limit_q;
			drv_s2 <= drv_s1;
			dvn_s2 <= dvn_s1;
			neg_s2 <= neg_s1;
			w_s2   <= w_s1;
		end
	end

	// stage 3: sum, limit compare, short direction test
	logic             vld_s3;
	logic [RAD_W-1:0] rad_s3;
	side_t            side_s3;
	logic [SUM_W-1:0] sum_c;
	logic             act_c;

	always_comb begin
		sum_c = sq_s2[0] + sq_s2[1] + sq_s2[2];
		if (mode_q) begin
			act_c = sum_c < SUM_W'(lsq_s2);
		end else begin
			act_c = sum_c > SUM_W'(lsq_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3       <= {sum_c, {(2*EXTRA_BITS){1'b0}}};
			side_s3.drv  <= drv_s2;
			side_s3.dvn  <= dvn_s2;
			side_s3.neg  <= neg_s2;
			for (int k = 0; k < 3; k++) begin
				side_s3.num[k] <= {nl_s2[k], {EXTRA_BITS{1'b0}}};
			end
			side_s3.w    <= w_s2;
			side_s3.pass <= (w_s2 == '0) || !act_c;
			side_s3.tiny <= sum_c < SUM_W'(TINY_SQ);
		end
	end

	// length with extra fraction bits
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;
	side_t             dv_side_in;

	dlc_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s3),
		.in_rad   (rad_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	always_comb begin
		dv_side_in      = sq_side;
		dv_side_in.tiny = sq_side.tiny || (sq_root == '0);
	end

	logic                dv_vld;
	logic [2:0][Q_W-1:0] dv_quo;
	side_t               dv_side;

	dlc_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (sq_vld),
		.in_den   (sq_root),
		.in_side  (dv_side_in),
		.out_vld  (dv_vld),
		.out_quo  (dv_quo),
		.out_side (dv_side)
	);

	// target and difference to the driven point
	logic                   vld_s4;
	logic [2:0]             dneg_s4;
	logic [2:0][DIFF_W-1:0] dmag_s4;
	logic [2:0][CRD_W-1:0]  dvn_s4;
	logic [W_W-1:0]         w_s4;
	logic                   pass_s4;
	logic [2:0][DIFF_W-1:0] diff_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [Q_W-1:0]    off;
			logic [DIFF_W-1:0] tgt;
			if (dv_side.tiny) begin
				off = (k == 2) ? limit_q : '0;
			end else begin
				off = dv_quo[k];
			end
			if (dv_side.neg[k] && !dv_side.tiny) begin
				tgt = DIFF_W'($signed(dv_side.drv[k])) - DIFF_W'(off);
			end else begin
				tgt = DIFF_W'($signed(dv_side.drv[k])) + DIFF_W'(off);
			end
			diff_c[k] = tgt - DIFF_W'($signed(dv_side.dvn[k]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				dneg_s4[k] <= diff_c[k][DIFF_W-1];
				dmag_s4[k] <= diff_c[k][DIFF_W-1] ? DIFF_W'(-diff_c[k]) : diff_c[k];
			end
			dvn_s4  <= dv_side.dvn;
			w_s4    <= dv_side.w;
			pass_s4 <= dv_side.pass;
		end
	end

	// stage 5: weighted step with rounding offset
	logic                   vld_s5;
	logic [2:0]             dneg_s5;
	logic [2:0][PROD_W-1:0] prod_s5;
	logic [2:0][CRD_W-1:0]  dvn_s5;
	logic                   pass_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				prod_s5[k] <= PROD_W'(dmag_s4[k]) * PROD_W'(w_s4) + PROD_W'(32768);
			end
			dneg_s5 <= dneg_s4;
			dvn_s5  <= dvn_s4;
			pass_s5 <= pass_s4;
		end
	end

	// stage 6: blend, saturate, output register
	logic                  vld_s6;
	out_item_t             item_s6;
	logic [2:0][CRD_W-1:0] res_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [STEP_W-1:0]       step;
			logic signed [RES_W-1:0] sum;
			step = prod_s5[k][PROD_W-1:16];
			if (dneg_s5[k]) begin
				sum = RES_W'($signed(dvn_s5[k])) - $signed({1'b0, step});
			end else begin
				sum = RES_W'($signed(dvn_s5[k])) + $signed({1'b0, step});
			end
			if (pass_s5) begin
				res_c[k] = dvn_s5[k];
			end else if (sum > RES_W'(signed'(64'sd2147483647))) begin
				res_c[k] = 32'h7fff_ffff;
			end else if (sum < RES_W'(signed'(-64'sd2147483648))) begin
				res_c[k] = 32'h8000_0000;
			end else begin
				res_c[k] = sum[CRD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s6.result_x <= res_c[0];
			item_s6.result_y <= res_c[1];
			item_s6.result_z <= res_c[2];
			item_s6.moved    <= !pass_s5;
		end
	end

	assign out_valid = vld_s6;
	assign out_item  = item_s6;

	// outside mode with a zero limit can never act
	a_no_move_zero_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_q && limit_q == '0 |-> !out_item.moved)
		else $error("item moved with zero limit in outside mode");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted item missing from first stage");

endmodule

FILE: rtl/dlc_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// dlc_sqrt_pipe
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module dlc_sqrt_pipe
	import dlc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  side_t             in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output side_t             out_side
);

	logic              vld_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	side_t             side_s [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		logic              vld_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		side_t             side_in;
		logic [REM_W-1:0]  cur;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_rad;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign rad_in  = rad_s[g-1];
			assign side_in = side_s[g-1];
		end

		assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= ge ? cur - trial : cur;
				root_s[g] <= {root_in[ROOT_W-2:0], ge};
				rad_s[g]  <= rad_in << 2;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];

endmodule

FILE: rtl/dlc_div_pipe.sv
// ----------------------------------------------------------------------------
// dlc_div_pipe
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module dlc_div_pipe
	import dlc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_vld,
	input  logic [ROOT_W-1:0]   in_den,
	input  side_t               in_side,
	output logic                out_vld,
	output logic [2:0][Q_W-1:0] out_quo,
	output side_t               out_side
);

	logic                       vld_s  [Q_W];
	logic [2:0][ROOT_W-1:0]     rem_s  [Q_W];
	logic [2:0][Q_W-1:0]        low_s  [Q_W];
	logic [2:0][Q_W-1:0]        quo_s  [Q_W];
	logic [ROOT_W-1:0]          den_s  [Q_W];
	side_t                      side_s [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		logic                   vld_in;
		logic [2:0][ROOT_W-1:0] rem_in;
		logic [2:0][Q_W-1:0]    low_in;
		logic [2:0][Q_W-1:0]    quo_in;
		logic [ROOT_W-1:0]      den_in;
		side_t                  side_in;
		logic [2:0][ROOT_W:0]   cur;
		logic [2:0]             ge;

		if (g == 0) begin : g_first
			assign vld_in  = in_vld;
			assign den_in  = in_den;
			assign side_in = in_side;
			assign quo_in  = '0;
			for (genvar k = 0; k < 3; k++) begin : g_lane
				// quotient is below 2^Q_W, so the top part is below the divisor
				assign rem_in[k] = ROOT_W'(in_side.num[k] >> Q_W);
				assign low_in[k] = in_side.num[k][Q_W-1:0];
			end
		end else begin : g_next
			assign vld_in  = vld_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign low_in  = low_s[g-1];
			assign quo_in  = quo_s[g-1];
			assign den_in  = den_s[g-1];
			assign side_in = side_s[g-1];
		end

		for (genvar k = 0; k < 3; k++) begin : g_cmp
			assign cur[k] = {rem_in[k], low_in[k][Q_W-1]};
			assign ge[k]  = cur[k] >= {1'b0, den_in};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int k = 0; k < 3; k++) begin
					rem_s[g][k] <= ge[k] ? ROOT_W'(cur[k] - {1'b0, den_in})
						: ROOT_W'(cur[k]);
					low_s[g][k] <= low_in[k] << 1;
					quo_s[g][k] <= {quo_in[k][Q_W-2:0], ge[k]};
				end
				den_s[g]  <= den_in;
				side_s[g] <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[Q_W-1];
	assign out_quo  = quo_s[Q_W-1];
	assign out_side = side_s[Q_W-1];

endmodule
